// File: rtl/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// mlrq_pkg
// shared constants and types for the multilevel ready queue scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package mlrq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned ID_BITS_DEF     = 8;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    localparam logic [1:0] LVL_RR   = 2'd0;
    localparam logic [1:0] LVL_FCFS = 2'd1;
    localparam logic [1:0] LVL_PRIO = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mlrq_fifo.sv
// ----------------------------------------------------------------------------
// mlrq_fifo
// circular ready queue with head and tail pointers, fill count and a
// registered read of the head word on pop
// ----------------------------------------------------------------------------
`default_nettype none

module mlrq_fifo #(
    parameter int unsigned DEPTH = mlrq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned WIDTH = mlrq_pkg::ID_BITS_DEF + 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mlrq_pkg::fifo_ctrl_t           ctrl,
    input  wire logic [WIDTH-1:0]               wdata,
    output logic      [WIDTH-1:0]               rdata,
    output logic      [$clog2(DEPTH+1)-1:0]     count
);

    import mlrq_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] rdata_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= wdata;
        end
        if (ctrl.pop)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign rdata = rdata_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// File: rtl/multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// three ready queues: two fifo levels and a priority level served by a
// sequential scan for the lowest priority and a compaction of the store
//
//   port group      direction  handshake
//   command word    in         taken on start high while busy low
//   result word     out        done high for one cycle, cannot be held off
//
// add and fifo pick: start edge, then the report state, done in the next cycle
// priority pick: scan of the n entries, compaction of the entries above b, report, done
//   (n entries in the priority level, b the place of the picked entry)
// the priority store has one write and one registered read port per cycle
// busy drops in the done cycle, so the next word can be taken then
// reset clears counts, pointers and control; stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_ready_queue_scheduler #(
    parameter int unsigned QUEUE_DEPTH = mlrq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned ID_BITS     = mlrq_pkg::ID_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       command,
    input  wire logic [7:0] process_id,
    input  wire logic [1:0] level,
    input  wire logic [7:0] priority_req,
    output logic            done,
    output logic      [1:0] status,
    output logic      [7:0] chosen_id,
    output logic      [1:0] chosen_level,
    output logic      [7:0] chosen_priority,
    output logic      [4:0] count_level0,
    output logic      [4:0] count_level1,
    output logic      [4:0] count_level2
);

    import mlrq_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned XW = PW + 1;
    localparam int unsigned EW = ID_BITS + 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_REPORT
    } state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_L0,
        SRC_L1,
        SRC_L2
    } src_t;

    state_t          state_reg, state_next;
    src_t            src_reg, src_next;
    logic [1:0]      pend_status_reg, pend_status_next;
    logic [CW-1:0]   cnt2_reg, cnt2_next;
    logic [PW-1:0]   scan_reg, scan_next;
    logic [PW-1:0]   best_idx_reg, best_idx_next;
    logic [EW-1:0]   best_reg, best_next;
    logic [PW-1:0]   sh_reg, sh_next;
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic [7:0]      cid_reg, cid_next;
    logic [1:0]      clev_reg, clev_next;
    logic [7:0]      cprio_reg, cprio_next;

    logic [EW-1:0]   l2_mem [QUEUE_DEPTH];
    logic [EW-1:0]   l2_rd_reg;
    logic            l2_we;
    logic [PW-1:0]   l2_waddr;
    logic [EW-1:0]   l2_wdata;
    logic            l2_re;
    logic [PW-1:0]   l2_raddr;

    fifo_ctrl_t      f0_ctrl, f1_ctrl;
    logic [EW-1:0]   f0_rdata, f1_rdata;
    logic [CW-1:0]   cnt0, cnt1;

    logic [ID_BITS+7:0] pid_wide;
    logic [EW-1:0]      entry_in;
    logic [XW-1:0]      cnt2_ext;
    logic [XW-1:0]      scan_plus;
    logic [XW-1:0]      best_plus;
    logic [XW-1:0]      sh_plus2;
    logic               take;
    logic [PW-1:0]      cand_idx;
    logic [EW-1:0]      cand;
    logic [EW-1:0]      report_entry;
    logic [ID_BITS+7:0] cid_wide;
    logic [CW+4:0]      cnt0_wide, cnt1_wide, cnt2_wide;

    assign pid_wide  = {{ID_BITS{1'b0}}, process_id};
    assign entry_in  = {pid_wide[ID_BITS-1:0], priority_req};
    assign cnt2_ext  = XW'(cnt2_reg);
    assign scan_plus = XW'(scan_reg) + XW'(1);
    assign sh_plus2  = XW'(sh_reg) + XW'(2);

    // running minimum, strict compare keeps the earliest of equal priorities
    assign take      = (scan_reg == '0) || (l2_rd_reg[7:0] < best_reg[7:0]);
    assign cand_idx  = take ? scan_reg : best_idx_reg;
    assign cand      = take ? l2_rd_reg : best_reg;
    assign best_plus = XW'(cand_idx) + XW'(1);

    mlrq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_fifo0 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (f0_ctrl),
        .wdata (entry_in),
        .rdata (f0_rdata),
        .count (cnt0)
    );

    mlrq_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_fifo1 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (f1_ctrl),
        .wdata (entry_in),
        .rdata (f1_rdata),
        .count (cnt1)
    );

    always_comb
    begin
        case (src_reg)
            SRC_L0:  report_entry = f0_rdata;
            SRC_L1:  report_entry = f1_rdata;
            SRC_L2:  report_entry = best_reg;
            default: report_entry = '0;
        endcase
    end

    assign cid_wide = {8'b0, report_entry[EW-1:8]};

    always_comb
    begin
        state_next       = state_reg;
        src_next         = src_reg;
        pend_status_next = pend_status_reg;
        cnt2_next        = cnt2_reg;
        scan_next        = scan_reg;
        best_idx_next    = best_idx_reg;
        best_next        = best_reg;
        sh_next          = sh_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        cid_next         = cid_reg;
        clev_next        = clev_reg;
        cprio_next       = cprio_reg;
        f0_ctrl          = '0;
        f1_ctrl          = '0;
        l2_we            = 1'b0;
        l2_waddr         = sh_reg;
        l2_wdata         = l2_rd_reg;
        l2_re            = 1'b0;
        l2_raddr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next       = S_REPORT;
                    src_next         = SRC_NONE;
                    pend_status_next = STATUS_DONE;
                    if (command == CMD_ADD)
                    begin
                        case (level)
                            LVL_RR:
                            begin
                                if (cnt0 >= CW'(QUEUE_DEPTH))
                                begin
                                    pend_status_next = STATUS_FULL;
                                end
                                else
                                begin
                                    f0_ctrl.push = 1'b1;
                                end
                            end
                            LVL_FCFS:
                            begin
                                if (cnt1 >= CW'(QUEUE_DEPTH))
                                begin
                                    pend_status_next = STATUS_FULL;
                                end
                                else
                                begin
                                    f1_ctrl.push = 1'b1;
                                end
                            end
                            LVL_PRIO:
                            begin
                                if (cnt2_reg >= CW'(QUEUE_DEPTH))
                                begin
                                    pend_status_next = STATUS_FULL;
                                end
                                else
                                begin
                                    l2_we     = 1'b1;
                                    l2_waddr  = cnt2_reg[PW-1:0];
                                    l2_wdata  = entry_in;
                                    cnt2_next = cnt2_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                                pend_status_next = STATUS_FULL;
                            end
                        endcase
                    end
                    else if (cnt0 != '0)
                    begin
                        f0_ctrl.pop = 1'b1;
                        src_next    = SRC_L0;
                    end
                    else if (cnt1 != '0)
                    begin
                        f1_ctrl.pop = 1'b1;
                        src_next    = SRC_L1;
                    end
                    else if (cnt2_reg != '0)
                    begin
                        l2_re      = 1'b1;
                        l2_raddr   = '0;
                        scan_next  = '0;
                        src_next   = SRC_L2;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                end
            end

            S_SCAN:
            begin
                best_idx_next = cand_idx;
                best_next     = cand;
                if (scan_plus < cnt2_ext)
                begin
                    l2_re     = 1'b1;
                    l2_raddr  = scan_plus[PW-1:0];
                    scan_next = scan_plus[PW-1:0];
                end
                else if (best_plus < cnt2_ext)
                begin
                    l2_re      = 1'b1;
                    l2_raddr   = best_plus[PW-1:0];
                    sh_next    = cand_idx;
                    state_next = S_SHIFT;
                end
                else
                begin
                    cnt2_next  = cnt2_reg - CW'(1);
                    state_next = S_REPORT;
                end
            end

            S_SHIFT:
            begin
                l2_we    = 1'b1;
                l2_waddr = sh_reg;
                l2_wdata = l2_rd_reg;
                if (sh_plus2 < cnt2_ext)
                begin
                    l2_re    = 1'b1;
                    l2_raddr = sh_plus2[PW-1:0];
                    sh_next  = sh_reg + PW'(1);
                end
                else
                begin
                    cnt2_next  = cnt2_reg - CW'(1);
                    state_next = S_REPORT;
                end
            end

            S_REPORT:
            begin
                done_next   = 1'b1;
                status_next = pend_status_reg;
                cid_next    = cid_wide[7:0];
                cprio_next  = report_entry[7:0];
                case (src_reg)
                    SRC_L1:  clev_next = LVL_FCFS;
                    SRC_L2:  clev_next = LVL_PRIO;
                    default: clev_next = LVL_RR;
                endcase
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[l2_waddr] <= l2_wdata;
        end
        if (l2_re)
        begin
            l2_rd_reg <= l2_mem[l2_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            src_reg         <= SRC_NONE;
            pend_status_reg <= STATUS_DONE;
            cnt2_reg        <= '0;
            scan_reg        <= '0;
            best_idx_reg    <= '0;
            best_reg        <= '0;
            sh_reg          <= '0;
            done_reg        <= 1'b0;
            status_reg      <= STATUS_DONE;
            cid_reg         <= '0;
            clev_reg        <= LVL_RR;
            cprio_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            src_reg         <= src_next;
            pend_status_reg <= pend_status_next;
            cnt2_reg        <= cnt2_next;
            scan_reg        <= scan_next;
            best_idx_reg    <= best_idx_next;
            best_reg        <= best_next;
            sh_reg          <= sh_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            cid_reg         <= cid_next;
            clev_reg        <= clev_next;
            cprio_reg       <= cprio_next;
        end
    end

    assign cnt0_wide = {5'b0, cnt0};
    assign cnt1_wide = {5'b0, cnt1};
    assign cnt2_wide = {5'b0, cnt2_reg};

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign chosen_id       = cid_reg;
    assign chosen_level    = clev_reg;
    assign chosen_priority = cprio_reg;
    assign count_level0    = cnt0_wide[4:0];
    assign count_level1    = cnt1_wide[4:0];
    assign count_level2    = cnt2_wide[4:0];

endmodule

`default_nettype wire

// File: tb/multilevel_ready_queue_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_test
// drives a directed sequence and then add and pick words into the scheduler
// in random bursts, keeps a shadow copy of the three ready queues and compares
// every report word, field by field, with the one the shadow predicts
// ----------------------------------------------------------------------------

module multilevel_ready_queue_scheduler_test;

    import mlrq_pkg::*;

    localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
    localparam logic [7:0]  ID_MASK      = 8'((1 << ID_BITS_DEF) - 1);
    localparam logic [1:0]  LVL_NONE     = 2'd3;
    localparam int          RANDOM_ITEMS = 1950;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          SETTLE       = 48;

    typedef struct packed {
        logic       command;
        logic [7:0] process_id;
        logic [1:0] level;
        logic [7:0] priority_req;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] chosen_id;
        logic [1:0] chosen_level;
        logic [7:0] chosen_priority;
        logic [4:0] count_level0;
        logic [4:0] count_level1;
        logic [4:0] count_level2;
    } report_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
    } slot_t;

    class ready_queue_shadow;
        slot_t   rr_q[$];
        slot_t   fcfs_q[$];
        slot_t   prio_q[$];
        report_t wanted_reports[$];
        int      failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return wanted_reports.size();
        endfunction

        function void take_command(cmd_word_t w);
            report_t r;
            slot_t   s;
            int      best;
            r      = '0;
            s.id   = w.process_id & ID_MASK;
            s.prio = w.priority_req;
            if (w.command == CMD_ADD)
            begin
                case (w.level)
                    LVL_RR:
                        if (rr_q.size() < DEPTH) rr_q.push_back(s);
                        else r.status = STATUS_FULL;
                    LVL_FCFS:
                        if (fcfs_q.size() < DEPTH) fcfs_q.push_back(s);
                        else r.status = STATUS_FULL;
                    LVL_PRIO:
                        if (prio_q.size() < DEPTH) prio_q.push_back(s);
                        else r.status = STATUS_FULL;
                    default:
                        r.status = STATUS_FULL;
                endcase
            end
            else if (rr_q.size() != 0)
            begin
                s                 = rr_q.pop_front();
                r.chosen_id       = s.id;
                r.chosen_priority = s.prio;
                r.chosen_level    = LVL_RR;
            end
            else if (fcfs_q.size() != 0)
            begin
                s                 = fcfs_q.pop_front();
                r.chosen_id       = s.id;
                r.chosen_priority = s.prio;
                r.chosen_level    = LVL_FCFS;
            end
            else if (prio_q.size() != 0)
            begin
                best = 0;
                for (int i = 1; i < prio_q.size(); i++)
                    if (prio_q[i].prio < prio_q[best].prio)
                        best = i;
                s = prio_q[best];
                prio_q.delete(best);
                r.chosen_id       = s.id;
                r.chosen_priority = s.prio;
                r.chosen_level    = LVL_PRIO;
            end
            else
            begin
                r.status = STATUS_EMPTY;
            end
            r.count_level0 = 5'(rr_q.size());
            r.count_level1 = 5'(fcfs_q.size());
            r.count_level2 = 5'(prio_q.size());
            wanted_reports.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void compare_report(report_t got);
            report_t want;
            if (wanted_reports.size() == 0)
            begin
                $display("%0t unexpected report word: expected none actual %0h", $time, got);
                failures++;
                return;
            end
            want = wanted_reports.pop_front();
            check_field("status", want.status, got.status);
            check_field("chosen_id", want.chosen_id, got.chosen_id);
            check_field("chosen_level", want.chosen_level, got.chosen_level);
            check_field("chosen_priority", want.chosen_priority, got.chosen_priority);
            check_field("count_level0", want.count_level0, got.count_level0);
            check_field("count_level1", want.count_level1, got.count_level1);
            check_field("count_level2", want.count_level2, got.count_level2);
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       start        = 1'b0;
    logic       command      = CMD_ADD;
    logic [7:0] process_id   = 8'd0;
    logic [1:0] level        = LVL_RR;
    logic [7:0] priority_req = 8'd0;

    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] chosen_id;
    logic [1:0] chosen_level;
    logic [7:0] chosen_priority;
    logic [4:0] count_level0;
    logic [4:0] count_level1;
    logic [4:0] count_level2;

    ready_queue_shadow shadow = new();
    int unsigned       cycle_count = 0;

    multilevel_ready_queue_scheduler u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .process_id      (process_id),
        .level           (level),
        .priority_req    (priority_req),
        .done            (done),
        .status          (status),
        .chosen_id       (chosen_id),
        .chosen_level    (chosen_level),
        .chosen_priority (chosen_priority),
        .count_level0    (count_level0),
        .count_level1    (count_level1),
        .count_level2    (count_level2)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[multilevel_ready_queue_scheduler] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.compare_report({status, chosen_id, chosen_level, chosen_priority,
                                   count_level0, count_level1, count_level2});
    end

    function automatic cmd_word_t mk(logic cmd, logic [7:0] id, logic [1:0] lvl,
                                     logic [7:0] prio);
        cmd_word_t w;
        w.command      = cmd;
        w.process_id   = id;
        w.level        = lvl;
        w.priority_req = prio;
        return w;
    endfunction

    // mode 1 leans on the priority level so that its scan and compaction get deep
    function automatic cmd_word_t random_word(int add_pct, int mode);
        cmd_word_t w;
        int        r;
        w.command    = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_PICK;
        w.process_id = 8'($urandom_range(255));
        r = $urandom_range(19);
        if (r == 19)
            w.level = LVL_NONE;
        else if (mode == 0)
            w.level = (r < 6) ? LVL_RR : (r < 12) ? LVL_FCFS : LVL_PRIO;
        else
            w.level = (r == 0) ? LVL_RR : (r == 1) ? LVL_FCFS : LVL_PRIO;
        case ($urandom_range(3))
            0:       w.priority_req = 8'($urandom_range(3));
            1:       w.priority_req = $urandom_range(1) ? 8'hff : 8'h00;
            default: w.priority_req = 8'($urandom_range(255));
        endcase
        return w;
    endfunction

    task automatic issue(input cmd_word_t w);
        start        <= 1'b1;
        command      <= w.command;
        process_id   <= w.process_id;
        level        <= w.level;
        priority_req <= w.priority_req;
        do
            @(posedge clk);
        while (busy);
        shadow.take_command(w);
    endtask

    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        issue(mk(CMD_PICK, 8'h00, LVL_RR, 8'h00));
        issue(mk(CMD_ADD, 8'h7e, LVL_NONE, 8'h81));
        issue(mk(CMD_ADD, 8'hff, LVL_RR, 8'hff));
        issue(mk(CMD_ADD, 8'h00, LVL_RR, 8'h00));
        issue(mk(CMD_ADD, 8'haa, LVL_FCFS, 8'h55));
        issue(mk(CMD_ADD, 8'h55, LVL_FCFS, 8'haa));
        // equal priorities: the earlier entry wins and order is kept
        issue(mk(CMD_ADD, 8'h01, LVL_PRIO, 8'h05));
        issue(mk(CMD_ADD, 8'h02, LVL_PRIO, 8'h05));
        issue(mk(CMD_ADD, 8'h03, LVL_PRIO, 8'h00));
        issue(mk(CMD_ADD, 8'h04, LVL_PRIO, 8'hff));
        issue(mk(CMD_ADD, 8'h05, LVL_PRIO, 8'h00));
        repeat (10) issue(mk(CMD_PICK, 8'hff, LVL_NONE, 8'hff));
    endtask

    initial
    begin
        int n_items;
        int seg_left;
        int add_pct;
        int mode;
        int burst;
        n_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        while (n_items < RANDOM_ITEMS)
        begin
            seg_left = $urandom_range(160, 40);
            if (seg_left > RANDOM_ITEMS - n_items)
                seg_left = RANDOM_ITEMS - n_items;
            mode     = $urandom_range(1);
            case ($urandom_range(4))
                0:       add_pct = 95;
                1:       add_pct = 75;
                2:       add_pct = 50;
                3:       add_pct = 30;
                default: add_pct = 5;
            endcase
            while (seg_left > 0)
            begin
                burst = $urandom_range(20, 1);
                if (burst > seg_left)
                    burst = seg_left;
                repeat (burst) issue(random_word(add_pct, mode));
                seg_left -= burst;
                n_items  += burst;
                if ($urandom_range(3) != 0)
                    idle($urandom_range(12, 1));
            end
            if ($urandom_range(4) == 0)
                drain();
        end
        drain();
        repeat (SETTLE) @(posedge clk);
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("[multilevel_ready_queue_scheduler] OK");
        else
            $display("[multilevel_ready_queue_scheduler] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/mlrq_pkg.sv
rtl/mlrq_fifo.sv
rtl/multilevel_ready_queue_scheduler.sv
tb/multilevel_ready_queue_scheduler_test.sv
